>>> rtl/core/itpc_pkg.sv
// Shared types, character constants and helper functions for the infix-to-postfix converter.
`timescale 1ns / 1ps

package itpc_pkg;

  // Stack entry codes
  typedef logic [2:0] code_t;

  localparam code_t CODE_LPAR = 3'd0;
  localparam code_t CODE_ADD  = 3'd1;
  localparam code_t CODE_SUB  = 3'd2;
  localparam code_t CODE_MUL  = 3'd3;
  localparam code_t CODE_DIV  = 3'd4;

  // ASCII characters the converter reacts to
  localparam logic [7:0] CH_LPAR = 8'h28;
  localparam logic [7:0] CH_RPAR = 8'h29;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_NUL  = 8'h00;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // latch the input word
    logic emit_sym;   // send latched symbol to output
    logic emit_top;   // send stack top to output and pop it
    logic emit_term;  // send terminator, clear overflow flag
    logic push;       // push code of latched symbol
    logic drop;       // pop stack top without output
    logic rd;         // read stack top into read register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_alnum;
    logic is_lpar;
    logic is_rpar;
    logic is_op;
    logic end_q;
    logic empty;
    logic top_lpar;
    logic top_ge;
    logic out_free;
    logic ovf;
  } sts_t;

  function automatic logic [7:0] code_char(input code_t c);
    logic [7:0] ch;
    case (c)
      CODE_LPAR: ch = CH_LPAR;
      CODE_ADD:  ch = CH_ADD;
      CODE_SUB:  ch = CH_SUB;
      CODE_MUL:  ch = CH_MUL;
      CODE_DIV:  ch = CH_DIV;
      default:   ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] prec_of(input code_t c);
    logic [1:0] p;
    case (c)
      CODE_ADD, CODE_SUB: p = 2'd1;
      CODE_MUL, CODE_DIV: p = 2'd2;
      default:            p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic code_t op_code(input logic [7:0] ch);
    code_t c;
    case (ch)
      CH_ADD:  c = CODE_ADD;
      CH_SUB:  c = CODE_SUB;
      CH_MUL:  c = CODE_MUL;
      CH_DIV:  c = CODE_DIV;
      default: c = CODE_LPAR;
    endcase
    return c;
  endfunction

  function automatic logic is_alnum_ch(input logic [7:0] ch);
    return (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A) ||
           (ch >= 8'h30 && ch <= 8'h39);
  endfunction

endpackage

>>> rtl/core/itpc_dp.sv
// Datapath: input latch, operator stack memory, stack count, overflow flag, output register.
`timescale 1ns / 1ps

module itpc_dp import itpc_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic [7:0] symbol,
  input  logic       end_of_expr,
  output logic [7:0] out_symbol,
  output logic       last,
  output logic       overflow,
  output logic       out_valid,
  input  logic       out_stall
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [7:0]    sym_q;
  logic          end_q;
  code_t         mem [STACK_DEPTH];
  code_t         rd_data;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] count_m1;
  logic          ovf;
  logic          full;
  code_t         push_code;
  logic          do_push;

  // Input latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sym_q <= symbol;
      end_q <= end_of_expr;
    end
  end

  assign full      = (count == CW'(STACK_DEPTH));
  assign count_m1  = count - CW'(1);
  assign push_code = (sym_q == CH_LPAR) ? CODE_LPAR : op_code(sym_q);
  assign do_push   = cmd.push && !full;

  // Stack memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[count[AW-1:0]] <= push_code;
    end
    if (cmd.rd) begin
      rd_data <= mem[count_m1[AW-1:0]];
    end
  end

  // Stack count
  always_comb begin
    count_next = count;
    if (do_push) begin
      count_next = count + CW'(1);
    end else if (cmd.emit_top || cmd.drop) begin
      count_next = count_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Sticky overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      ovf <= 1'b0;
    end else if (cmd.emit_term) begin
      ovf <= 1'b0;
    end else if (cmd.push && full) begin
      ovf <= 1'b1;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.emit_sym) begin
      out_symbol <= sym_q;
      last       <= 1'b0;
      overflow   <= ovf;
    end else if (cmd.emit_top) begin
      out_symbol <= code_char(rd_data);
      last       <= 1'b0;
      overflow   <= ovf;
    end else if (cmd.emit_term) begin
      out_symbol <= CH_NUL;
      last       <= 1'b1;
      overflow   <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sym || cmd.emit_top || cmd.emit_term) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Status back to controller
  always_comb begin
    sts.is_alnum = is_alnum_ch(sym_q);
    sts.is_lpar  = (sym_q == CH_LPAR);
    sts.is_rpar  = (sym_q == CH_RPAR);
    sts.is_op    = (sym_q == CH_ADD) || (sym_q == CH_SUB) ||
                   (sym_q == CH_MUL) || (sym_q == CH_DIV);
    sts.end_q    = end_q;
    sts.empty    = (count == '0);
    sts.top_lpar = (rd_data == CODE_LPAR);
    sts.top_ge   = (prec_of(rd_data) >= prec_of(op_code(sym_q)));
    sts.out_free = !out_valid || !out_stall;
    sts.ovf      = ovf;
  end

endmodule

>>> rtl/core/itpc_ctrl.sv
// Controller: state machine sequencing classify, stack reads, pops, pushes and the final drain.
`timescale 1ns / 1ps

module itpc_ctrl import itpc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLASS = 6'b000010,
    S_RD    = 6'b000100,
    S_EVAL  = 6'b001000,
    S_DRD   = 6'b010000,
    S_DEV   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  state_t after;

  // Where to go once the word itself is handled
  assign after = sts.end_q ? S_DRD : S_IDLE;

  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        if (sts.is_alnum) begin
          if (sts.out_free) begin
            cmd.emit_sym = 1'b1;
            state_next   = after;
          end
        end else if (sts.is_lpar) begin
          cmd.push   = 1'b1;
          state_next = after;
        end else if (sts.is_rpar || sts.is_op) begin
          state_next = S_RD;
        end else begin
          state_next = after;
        end
      end
      S_RD: begin
        if (sts.empty) begin
          cmd.push   = sts.is_op;
          state_next = after;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.is_rpar) begin
          if (sts.top_lpar) begin
            cmd.drop   = 1'b1;
            state_next = after;
          end else if (sts.out_free) begin
            cmd.emit_top = 1'b1;
            state_next   = S_RD;
          end
        end else if (sts.top_ge) begin
          if (sts.out_free) begin
            cmd.emit_top = 1'b1;
            state_next   = S_RD;
          end
        end else begin
          cmd.push   = 1'b1;
          state_next = after;
        end
      end
      S_DRD: begin
        if (sts.empty) begin
          if (sts.out_free) begin
            cmd.emit_term = 1'b1;
            state_next    = S_IDLE;
          end
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_DEV;
        end
      end
      S_DEV: begin
        if (sts.out_free) begin
          cmd.emit_top = 1'b1;
          state_next   = S_DRD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/infix_to_postfix_converter_unit.sv
// Top level of the infix-to-postfix converter: controller, datapath and checks.
`timescale 1ns / 1ps

// Converts an infix character stream to postfix with an operator stack (shunting-yard).
// One character is taken per input word; letters and digits pass through, + - * / and
// brackets go through a STACK_DEPTH-entry stack memory, and the word marked end_of_expr
// drains the stack and closes the output with a NUL word that has last set. Words are
// handled one at a time: each word is latched and then classified, and ')' or an operator
// then reads the stack top and pops operators until the stack is empty or it stops at a
// stacked entry; each stack read goes through the registered read port of the stack memory.
// The end drain reads and emits each stacked entry in turn and then the terminator. Output
// stall holds these steps only when a result word is still waiting in the output register.

module infix_to_postfix_converter_unit import itpc_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] symbol,
  input  logic       end_of_expr,
  input  logic       in_valid,
  output logic       in_stall,
  output logic [7:0] out_symbol,
  output logic       last,
  output logic       overflow,
  output logic       out_valid,
  input  logic       out_stall
);

  cmd_t cmd;
  sts_t sts;

  itpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  itpc_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .symbol      (symbol),
    .end_of_expr (end_of_expr),
    .out_symbol  (out_symbol),
    .last        (last),
    .overflow    (overflow),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
  );

  // Output register is only loaded when its word is gone or leaving
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sym || cmd.emit_top || cmd.emit_term) |-> sts.out_free)
    else $error("output word overwritten");

  // Pops only from a non-empty stack
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_top || cmd.drop) |-> !sts.empty)
    else $error("pop on empty stack");

  // After the terminator the stack is empty and the overflow flag cleared
  a_term_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_term |=> (sts.empty && !sts.ovf))
    else $error("state not cleared after terminator");

  // A taken word blocks the input until it is handled
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> in_stall)
    else $error("input not held off while busy");

endmodule
